### sv/ges_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ges_pkg
// Shared widths, codes and helpers of the gravity Euler step unit.
// ----------------------------------------------------------------------------
package ges_pkg;

    localparam int VAL_W   = 48;
    localparam int MU_W    = 52;
    localparam int DT_W    = 32;
    localparam int DMAG_W  = VAL_W + 1;
    localparam int SUM_W   = 2 * DMAG_W;
    localparam int ROOT_W  = DMAG_W;
    localparam int DEN_W   = SUM_W + 50;
    localparam int MULA_W  = MU_W + DMAG_W;
    localparam int MULB_W  = 50;
    localparam int ACC_W   = 150;
    localparam int Q_W     = 49;
    localparam int MAG_W   = 56;
    localparam int CNT_W   = 6;
    localparam int AXES    = 3;
    localparam int IN_W    = 320;
    localparam int OUT_W   = 296;

    localparam logic [CNT_W-1:0] MUL_LAST  = 6'd49;
    localparam logic [CNT_W-1:0] SQRT_LAST = 6'd48;
    localparam logic [CNT_W-1:0] DIV_LAST  = 6'd48;

    localparam logic [MU_W-1:0] MU_RESET = 52'd398600000000000;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [1:0] FAULT_OK   = 2'd0;
    localparam logic [1:0] FAULT_ZERO = 2'd1;
    localparam logic [1:0] FAULT_SAT  = 2'd2;

    localparam logic [1:0] REG_MU = 2'd0;
    localparam logic [1:0] REG_CX = 2'd1;
    localparam logic [1:0] REG_CY = 2'd2;
    localparam logic [1:0] REG_CZ = 2'd3;

    typedef logic signed [VAL_W-1:0] val_t;

    typedef enum logic [14:0] {
        ST_IDLE = 15'b000000000000001,
        ST_DIFF = 15'b000000000000010,
        ST_SQ   = 15'b000000000000100,
        ST_MUL  = 15'b000000000001000,
        ST_SACC = 15'b000000000010000,
        ST_SQRT = 15'b000000000100000,
        ST_DEN  = 15'b000000001000000,
        ST_NUM1 = 15'b000000010000000,
        ST_NUM2 = 15'b000000100000000,
        ST_DIVI = 15'b000001000000000,
        ST_DIV  = 15'b000010000000000,
        ST_VUPD = 15'b000100000000000,
        ST_PMUL = 15'b001000000000000,
        ST_PUPD = 15'b010000000000000,
        ST_OUT  = 15'b100000000000000
    } state_t;

    // returns {saturated, value}
    function automatic logic [VAL_W:0] sat_move(input val_t x, input logic neg,
                                                input logic [MAG_W-1:0] mag,
                                                input logic huge);
        logic [VAL_W+10:0] ext;
        logic [VAL_W+10:0] m;
        logic [VAL_W+10:0] sum;
        logic              ovf;
        ext = {{11{x[VAL_W-1]}}, x};
        m   = {3'b000, mag};
        sum = neg ? (ext - m) : (ext + m);
        ovf = huge | !((&sum[VAL_W+10:VAL_W-1]) | ~(|sum[VAL_W+10:VAL_W-1]));
        if (ovf)
        begin
            sat_move = neg ? {1'b1, 1'b1, {(VAL_W-1){1'b0}}}
                           : {1'b1, 1'b0, {(VAL_W-1){1'b1}}};
        end
        else
        begin
            sat_move = {1'b0, sum[VAL_W-1:0]};
        end
    endfunction

endpackage

### sv/gravity_euler_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gravity_euler_step_unit
// Explicit Euler step of one body under point-mass gravity, fixed point.
// ----------------------------------------------------------------------------
// Load transaction: passes through ST_OUT to the result register, waiting there while an
// earlier result is untaken. Step transaction: 3 squares, 49-step square root, 10 more
// shift-add multiplies and 3 divisions of 49 steps on one shared 150-bit add/subtract
// unit; zero distance skips the root, divisions and velocity update, and an overflowing
// quotient skips that axis's division. One item in flight; s_tready is high only while idle.
// rst_n clears body state to zero, registers to their reset values, no pending result.
module gravity_euler_step_unit
    import ges_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, time_step
    input  logic [IN_W-1:0]   s_tdata,
    // operation
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z, fault, pad
    output logic [OUT_W-1:0]  m_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    state_t               state_reg, state_next, mret_reg, mret_next;
    logic [MU_W-1:0]      mu_reg;
    val_t                 cen_reg [AXES];
    val_t                 pos_reg [AXES], pos_next [AXES];
    val_t                 vel_reg [AXES], vel_next [AXES];
    val_t                 newv_reg [AXES], newv_next [AXES];
    logic [DMAG_W-1:0]    dmag_reg [AXES], dmag_next [AXES];
    logic                 dneg_reg [AXES], dneg_next [AXES];
    logic [1:0]           axis_reg, axis_next;
    logic [DT_W-1:0]      dt_reg, dt_next;
    logic [SUM_W-1:0]     s_reg, s_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [MULA_W-1:0]    mula_reg, mula_next;
    logic [MULB_W-1:0]    mulb_reg, mulb_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [Q_W-1:0]       divq_reg, divq_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 huge_reg, huge_next;
    logic                 sat_reg, sat_next;
    logic                 zero_reg, zero_next;
    logic [1:0]           fault_reg, fault_next;
    logic                 mvalid_reg, mvalid_next;
    logic [OUT_W-1:0]     mdata_reg, mdata_next;

    logic [ACC_W-1:0]     alu_x, alu_y;
    logic                 alu_sub;
    logic [ACC_W:0]       alu_full;
    logic                 alu_ge;
    logic                 cfg_wr;
    logic [DMAG_W-1:0]    diff [AXES];
    logic [VAL_W-1:0]     vmag;
    logic [VAL_W:0]       mv;

    assign cfg_wr   = psel & penable & pwrite & pready;
    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    always_comb
    begin
        unique case (paddr[4:3])
            REG_MU:  prdata = {12'd0, mu_reg};
            REG_CX:  prdata = {{16{cen_reg[0][VAL_W-1]}}, cen_reg[0]};
            REG_CY:  prdata = {{16{cen_reg[1][VAL_W-1]}}, cen_reg[1]};
            REG_CZ:  prdata = {{16{cen_reg[2][VAL_W-1]}}, cen_reg[2]};
            default: prdata = '0;
        endcase
    end

    // shared add/subtract unit
    always_comb
    begin
        alu_x   = '0;
        alu_y   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_MUL:
            begin
                alu_x = {acc_reg[ACC_W-2:0], 1'b0};
                alu_y = mulb_reg[MULB_W-1] ? {{(ACC_W-MULA_W){1'b0}}, mula_reg} : '0;
            end
            ST_SACC:
            begin
                alu_x = {{(ACC_W-SUM_W){1'b0}}, s_reg};
                alu_y = acc_reg;
            end
            ST_SQRT:
            begin
                alu_x   = {{(ACC_W-52){1'b0}}, acc_reg[49:0], mula_reg[SUM_W-1:SUM_W-2]};
                alu_y   = {{(ACC_W-51){1'b0}}, root_reg, 2'b01};
                alu_sub = 1'b1;
            end
            ST_DIVI:
            begin
                alu_x   = {50'd0, acc_reg[132:33]};
                alu_y   = {2'b00, den_reg};
                alu_sub = 1'b1;
            end
            ST_DIV:
            begin
                alu_x   = {1'b0, acc_reg[DEN_W-1:0], divq_reg[Q_W-1]};
                alu_y   = {2'b00, den_reg};
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_x = '0;
            end
        endcase
        alu_full = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
                 + {{ACC_W{1'b0}}, alu_sub};
        alu_ge   = alu_full[ACC_W];
    end

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            diff[i] = {cen_reg[i][VAL_W-1], cen_reg[i]} - {pos_reg[i][VAL_W-1], pos_reg[i]};
        end
        vmag = vel_reg[axis_reg][VAL_W-1] ? (~vel_reg[axis_reg] + 1'b1) : vel_reg[axis_reg];
        mv   = '0;

        state_next  = state_reg;
        mret_next   = mret_reg;
        pos_next    = pos_reg;
        vel_next    = vel_reg;
        newv_next   = newv_reg;
        dmag_next   = dmag_reg;
        dneg_next   = dneg_reg;
        axis_next   = axis_reg;
        dt_next     = dt_reg;
        s_next      = s_reg;
        root_next   = root_reg;
        den_next    = den_reg;
        mula_next   = mula_reg;
        mulb_next   = mulb_reg;
        acc_next    = acc_reg;
        divq_next   = divq_reg;
        cnt_next    = cnt_reg;
        huge_next   = huge_reg;
        sat_next    = sat_reg;
        zero_next   = zero_reg;
        fault_next  = fault_reg;
        mvalid_next = mvalid_reg & ~m_tready;
        mdata_next  = mdata_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == OP_STEP)
                    begin
                        dt_next    = s_tdata[319:288];
                        state_next = ST_DIFF;
                    end
                    else
                    begin
                        for (int i = 0; i < AXES; i++)
                        begin
                            pos_next[i] = s_tdata[i*VAL_W +: VAL_W];
                            vel_next[i] = s_tdata[(i+3)*VAL_W +: VAL_W];
                        end
                        fault_next = FAULT_OK;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIFF:
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    dneg_next[i] = diff[i][DMAG_W-1];
                    dmag_next[i] = diff[i][DMAG_W-1] ? (~diff[i] + 1'b1) : diff[i];
                end
                axis_next  = 2'd0;
                s_next     = '0;
                sat_next   = 1'b0;
                zero_next  = 1'b0;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                mula_next  = {{(MULA_W-DMAG_W){1'b0}}, dmag_reg[axis_reg]};
                mulb_next  = {1'b0, dmag_reg[axis_reg]};
                acc_next   = '0;
                cnt_next   = MUL_LAST;
                mret_next  = ST_SACC;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                acc_next  = alu_full[ACC_W-1:0];
                mulb_next = {mulb_reg[MULB_W-2:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = mret_reg;
                end
            end
            ST_SACC:
            begin
                s_next = alu_full[SUM_W-1:0];
                if (axis_reg == 2'd2)
                begin
                    axis_next = 2'd0;
                    if (alu_full[SUM_W-1:0] == '0)
                    begin
                        zero_next  = 1'b1;
                        state_next = ST_PMUL;
                    end
                    else
                    begin
                        mula_next  = {{(MULA_W-SUM_W){1'b0}}, alu_full[SUM_W-1:0]};
                        acc_next   = '0;
                        root_next  = '0;
                        cnt_next   = SQRT_LAST;
                        state_next = ST_SQRT;
                    end
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_SQRT:
            begin
                if (alu_ge)
                begin
                    acc_next  = {100'd0, alu_full[49:0]};
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    acc_next  = {98'd0, acc_reg[49:0], mula_reg[SUM_W-1:SUM_W-2]};
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                mula_next = {mula_reg[MULA_W-3:0], 2'b00};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DEN;
                end
            end
            ST_DEN:
            begin
                mula_next  = {{(MULA_W-SUM_W){1'b0}}, s_reg};
                mulb_next  = {1'b0, root_reg};
                acc_next   = '0;
                cnt_next   = MUL_LAST;
                mret_next  = ST_NUM1;
                state_next = ST_MUL;
            end
            ST_NUM1:
            begin
                if (axis_reg == 2'd0)
                begin
                    den_next = acc_reg[DEN_W-1:0];
                end
                mula_next  = {{(MULA_W-MU_W){1'b0}}, mu_reg};
                mulb_next  = {1'b0, dmag_reg[axis_reg]};
                acc_next   = '0;
                cnt_next   = MUL_LAST;
                mret_next  = ST_NUM2;
                state_next = ST_MUL;
            end
            ST_NUM2:
            begin
                mula_next  = acc_reg[MULA_W-1:0];
                mulb_next  = {{(MULB_W-DT_W){1'b0}}, dt_reg};
                acc_next   = '0;
                cnt_next   = MUL_LAST;
                mret_next  = ST_DIVI;
                state_next = ST_MUL;
            end
            ST_DIVI:
            begin
                huge_next = alu_ge;
                acc_next  = {50'd0, acc_reg[132:33]};
                divq_next = {acc_reg[32:0], 16'd0};
                cnt_next  = DIV_LAST;
                state_next = alu_ge ? ST_VUPD : ST_DIV;
            end
            ST_DIV:
            begin
                if (alu_ge)
                begin
                    acc_next = alu_full[ACC_W-1:0];
                end
                else
                begin
                    acc_next = {acc_reg[ACC_W-2:0], divq_reg[Q_W-1]};
                end
                divq_next = {divq_reg[Q_W-2:0], alu_ge};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_VUPD;
                end
            end
            ST_VUPD:
            begin
                mv = sat_move(vel_reg[axis_reg], dneg_reg[axis_reg],
                              {{(MAG_W-Q_W){1'b0}}, divq_reg}, huge_reg);
                newv_next[axis_reg] = mv[VAL_W-1:0];
                sat_next            = sat_reg | mv[VAL_W];
                if (axis_reg == 2'd2)
                begin
                    axis_next  = 2'd0;
                    state_next = ST_PMUL;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_NUM1;
                end
            end
            ST_PMUL:
            begin
                mula_next  = {{(MULA_W-VAL_W){1'b0}}, vmag};
                mulb_next  = {{(MULB_W-DT_W){1'b0}}, dt_reg};
                acc_next   = '0;
                cnt_next   = MUL_LAST;
                mret_next  = ST_PUPD;
                state_next = ST_MUL;
            end
            ST_PUPD:
            begin
                mv = sat_move(pos_reg[axis_reg], vel_reg[axis_reg][VAL_W-1],
                              acc_reg[79:24], 1'b0);
                pos_next[axis_reg] = mv[VAL_W-1:0];
                if (axis_reg == 2'd2)
                begin
                    axis_next = 2'd0;
                    if (!zero_reg)
                    begin
                        vel_next = newv_reg;
                    end
                    if (zero_reg)
                    begin
                        fault_next = FAULT_ZERO;
                    end
                    else if (sat_reg | mv[VAL_W])
                    begin
                        fault_next = FAULT_SAT;
                    end
                    else
                    begin
                        fault_next = FAULT_OK;
                    end
                    state_next = ST_OUT;
                end
                else
                begin
                    sat_next   = sat_reg | mv[VAL_W];
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_PMUL;
                end
            end
            ST_OUT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {6'd0, fault_reg, vel_reg[2], vel_reg[1], vel_reg[0],
                                   pos_reg[2], pos_reg[1], pos_reg[0]};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mret_reg   <= ST_IDLE;
            mu_reg     <= MU_RESET;
            axis_reg   <= 2'd0;
            mvalid_reg <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                cen_reg[i] <= '0;
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            mret_reg   <= mret_next;
            axis_reg   <= axis_next;
            mvalid_reg <= mvalid_next;
            pos_reg    <= pos_next;
            vel_reg    <= vel_next;
            if (cfg_wr)
            begin
                unique case (paddr[4:3])
                    REG_MU:  mu_reg     <= pwdata[MU_W-1:0];
                    REG_CX:  cen_reg[0] <= pwdata[VAL_W-1:0];
                    REG_CY:  cen_reg[1] <= pwdata[VAL_W-1:0];
                    REG_CZ:  cen_reg[2] <= pwdata[VAL_W-1:0];
                    default: mu_reg     <= mu_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        newv_reg  <= newv_next;
        dmag_reg  <= dmag_next;
        dneg_reg  <= dneg_next;
        dt_reg    <= dt_next;
        s_reg     <= s_next;
        root_reg  <= root_next;
        den_reg   <= den_next;
        mula_reg  <= mula_next;
        mulb_reg  <= mulb_next;
        acc_reg   <= acc_next;
        divq_reg  <= divq_next;
        cnt_reg   <= cnt_next;
        huge_reg  <= huge_next;
        sat_reg   <= sat_next;
        zero_reg  <= zero_next;
        fault_reg <= fault_next;
        mdata_reg <= mdata_next;
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == OP_LOAD)) |=> (state_reg == ST_OUT))
        else $error("load transaction did not go to output");

    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_OUT) && (!m_tvalid || m_tready)) |=>
            (m_tvalid && (state_reg == ST_IDLE)))
        else $error("result not presented");

    a_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[289:288] != 2'b11))
        else $error("undefined fault code");

endmodule
